// ----- design/keyframe_vector_interpolator_unit_macros.svh -----
// Assertion macros used by the port checker of the keyframe interpolator.
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_UNIT_MACROS_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_UNIT_MACROS_SVH

// Checked on every rising edge outside reset.
`define KVIU_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("keyframe interpolator check failed");

// Checked on every rising edge, reset included.
`define KVIU_ASSERT_ANY(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("keyframe interpolator check failed during reset");

`endif

// ----- design/kviu_pkg.sv -----
// Package of the keyframe interpolator: constants and controller/datapath types.
package kviu_pkg;

    localparam int MAX_KEYS_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int FRAC_W       = 16;
    localparam int CNT_W        = 5;
    localparam int IDX_W        = 4;

    localparam logic [1:0] RES_NONE = 2'd0;
    localparam logic [1:0] RES_KEYA = 2'd1;
    localparam logic [1:0] RES_READ = 2'd2;
    localparam logic [1:0] RES_LERP = 2'd3;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic       ld_tq;
        logic       ld_a;
        logic       ld_b;
        logic       div_init;
        logic       div_step;
        logic       mul;
        logic [1:0] comp;
        logic [1:0] res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic tq_le_rd;
        logic tq_ge_rd;
        logic t2_le_t1;
    } t_dp_status;

endpackage

// ----- design/keyframe_vector_interpolator_unit.sv -----
// Keyframe interpolator top level: configuration port, controller and datapath.
// A write transfer stores one keyframe. An evaluate transfer returns the first
// key when the query lies at or before it, the last key when the query lies at
// or after it, and otherwise blends the two keys of the segment that holds it,
// or returns the segment's first key if their times do not ascend: the search
// reads one key per cycle from the single read port of the key memory, the
// fraction comes from a one bit per cycle divider, and one shared multiplier
// blends the three components in turn. The block takes one transfer at a time
// and holds o_stall high until the result has been taken. keys_in_use sits at
// byte address 0 and resets to 1.
module keyframe_vector_interpolator_unit #(
    parameter int MAX_KEYS = kviu_pkg::MAX_KEYS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_command,
    input  logic [kviu_pkg::IDX_W-1:0]        i_key_index,
    input  logic [kviu_pkg::DATA_W-1:0]       i_time_value,
    input  logic signed [kviu_pkg::DATA_W-1:0] i_value_x,
    input  logic signed [kviu_pkg::DATA_W-1:0] i_value_y,
    input  logic signed [kviu_pkg::DATA_W-1:0] i_value_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [kviu_pkg::DATA_W-1:0] o_out_x,
    output logic signed [kviu_pkg::DATA_W-1:0] o_out_y,
    output logic signed [kviu_pkg::DATA_W-1:0] o_out_z
);
    localparam int AW = $clog2(MAX_KEYS);

    logic [kviu_pkg::CNT_W-1:0] r_keys_in_use;
    kviu_pkg::t_dp_cmd          cmd;
    kviu_pkg::t_dp_status       status;
    logic [AW-1:0]              rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys_in_use <= kviu_pkg::CNT_W'(1);
        end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
            r_keys_in_use <= pwdata[kviu_pkg::CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? 32'(r_keys_in_use) : '0;

    kviu_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_command    (i_command),
        .i_key_index  (i_key_index),
        .i_keys_in_use(r_keys_in_use),
        .i_stall      (i_stall),
        .i_status     (status),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .o_cmd        (cmd),
        .o_rd_addr    (rd_addr)
    );

    kviu_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .i_key_index (i_key_index),
        .i_time_value(i_time_value),
        .i_value_x   (i_value_x),
        .i_value_y   (i_value_y),
        .i_value_z   (i_value_z),
        .o_status    (status),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z)
    );
endmodule

// ----- design/kviu_datapath.sv -----
// Datapath of the keyframe interpolator: key memories, search registers, divider, blend.
module kviu_datapath #(
    parameter int MAX_KEYS = kviu_pkg::MAX_KEYS_DEF,
    localparam int AW = $clog2(MAX_KEYS)
) (
    input  logic                              i_clk,
    input  kviu_pkg::t_dp_cmd                 i_cmd,
    input  logic [AW-1:0]                     i_rd_addr,
    input  logic [kviu_pkg::IDX_W-1:0]        i_key_index,
    input  logic [kviu_pkg::DATA_W-1:0]       i_time_value,
    input  logic signed [kviu_pkg::DATA_W-1:0] i_value_x,
    input  logic signed [kviu_pkg::DATA_W-1:0] i_value_y,
    input  logic signed [kviu_pkg::DATA_W-1:0] i_value_z,
    output kviu_pkg::t_dp_status              o_status,
    output logic signed [kviu_pkg::DATA_W-1:0] o_out_x,
    output logic signed [kviu_pkg::DATA_W-1:0] o_out_y,
    output logic signed [kviu_pkg::DATA_W-1:0] o_out_z
);
    localparam int DW = kviu_pkg::DATA_W;
    localparam int VW = 3 * DW;
    localparam int FW = kviu_pkg::FRAC_W;
    localparam int PW = DW + 1 + FW + 1;

    logic [DW-1:0] mem_t [MAX_KEYS];
    logic [VW-1:0] mem_v [MAX_KEYS];

    logic [DW-1:0] r_rd_t;
    logic [VW-1:0] r_rd_v;
    logic [DW-1:0] r_tq, r_t1, r_t2, r_len, r_rem;
    logic [VW-1:0] r_va, r_vb;
    logic [FW-1:0] r_quo;
    logic signed [PW-1:0] r_prod;
    logic [DW-1:0] r_res [3];

    logic [DW:0]          rem2;
    logic                 take;
    logic signed [DW:0]   diff;
    logic signed [DW-1:0] comp_a, comp_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem_t[AW'(i_key_index)] <= i_time_value;
            mem_v[AW'(i_key_index)] <= {i_value_z, i_value_y, i_value_x};
        end
        if (i_cmd.rd_en) begin
            r_rd_t <= mem_t[i_rd_addr];
            r_rd_v <= mem_v[i_rd_addr];
        end
    end

    // Restoring division: the remainder stays below the segment length,
    // so sixteen steps give the whole Q0.16 fraction.
    assign rem2 = {r_rem, 1'b0};
    assign take = rem2 >= {1'b0, r_len};

    assign comp_a = r_va[i_cmd.comp*DW +: DW];
    assign comp_b = r_vb[i_cmd.comp*DW +: DW];
    assign diff   = {comp_b[DW-1], comp_b} - {comp_a[DW-1], comp_a};

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_tq) begin
            r_tq <= i_time_value;
        end
        if (i_cmd.ld_a) begin
            r_t1 <= r_rd_t;
            r_va <= r_rd_v;
        end
        if (i_cmd.ld_b) begin
            r_t2 <= r_rd_t;
            r_vb <= r_rd_v;
        end
        if (i_cmd.div_init) begin
            r_rem <= r_tq - r_t1;
            r_len <= r_t2 - r_t1;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= take ? DW'(rem2 - {1'b0, r_len}) : DW'(rem2);
            r_quo <= {r_quo[FW-2:0], take};
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(diff) * PW'($signed({1'b0, r_quo}));
        end
        unique case (i_cmd.res_sel)
            kviu_pkg::RES_KEYA: begin
                r_res[0] <= r_va[0 +: DW];
                r_res[1] <= r_va[DW +: DW];
                r_res[2] <= r_va[2*DW +: DW];
            end
            kviu_pkg::RES_READ: begin
                r_res[0] <= r_rd_v[0 +: DW];
                r_res[1] <= r_rd_v[DW +: DW];
                r_res[2] <= r_rd_v[2*DW +: DW];
            end
            kviu_pkg::RES_LERP: begin
                // a + floor((b - a) * f / 2^16); the product bits from bit 16 up are the floor.
                r_res[i_cmd.comp] <= comp_a + r_prod[FW +: DW];
            end
            default: begin
            end
        endcase
    end

    assign o_status.tq_le_rd = r_tq <= r_rd_t;
    assign o_status.tq_ge_rd = r_tq >= r_rd_t;
    assign o_status.t2_le_t1 = r_t2 <= r_t1;

    assign o_out_x = r_res[0];
    assign o_out_y = r_res[1];
    assign o_out_z = r_res[2];
endmodule

// ----- design/kviu_ctrl.sv -----
// Controller of the keyframe interpolator: clamp, key search, divide and blend sequencing.
module kviu_ctrl #(
    parameter int MAX_KEYS = kviu_pkg::MAX_KEYS_DEF,
    localparam int AW = $clog2(MAX_KEYS)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_command,
    input  logic [kviu_pkg::IDX_W-1:0]     i_key_index,
    input  logic [kviu_pkg::CNT_W-1:0]     i_keys_in_use,
    input  logic                           i_stall,
    input  kviu_pkg::t_dp_status           i_status,
    output logic                           o_stall,
    output logic                           o_valid,
    output kviu_pkg::t_dp_cmd              o_cmd,
    output logic [AW-1:0]                  o_rd_addr
);
    localparam int NW = $clog2(MAX_KEYS + 1);
    localparam int EW = ((NW > kviu_pkg::CNT_W) ? NW : kviu_pkg::CNT_W) + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK0 = 4'd1;
    localparam logic [3:0] S_CHKN = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_DIVI = 4'd4;
    localparam logic [3:0] S_DIVS = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_k, n_k;
    logic [3:0]    r_cnt, n_cnt;
    logic [1:0]    r_comp, n_comp;

    logic [EW-1:0] kext;
    logic [NW-1:0] keys_n;
    logic          more_keys;
    logic          idx_ok;

    always_comb begin
        kext = EW'(i_keys_in_use);
        if (kext == '0) begin
            keys_n = NW'(1);
        end else if (kext > EW'(MAX_KEYS)) begin
            keys_n = NW'(MAX_KEYS);
        end else begin
            keys_n = NW'(kext);
        end
    end

    assign more_keys = (EW'(r_k) + EW'(2)) < EW'(keys_n);
    assign idx_ok    = 32'(i_key_index) < 32'(MAX_KEYS);

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_comp    = r_comp;
        o_cmd     = '0;
        o_cmd.comp = r_comp;
        o_cmd.res_sel = kviu_pkg::RES_NONE;
        o_rd_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_command == kviu_pkg::CMD_EVAL) begin
                        o_cmd.ld_tq = 1'b1;
                        o_cmd.rd_en = 1'b1;
                        n_state     = S_CHK0;
                    end else begin
                        o_cmd.wr_en = idx_ok;
                    end
                end
            end
            S_CHK0: begin
                o_cmd.ld_a = 1'b1;
                if (i_status.tq_le_rd) begin
                    o_cmd.res_sel = kviu_pkg::RES_READ;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = AW'(keys_n - NW'(1));
                    n_state     = S_CHKN;
                end
            end
            S_CHKN: begin
                if (i_status.tq_ge_rd) begin
                    o_cmd.res_sel = kviu_pkg::RES_READ;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = AW'(1);
                    n_k         = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                // The read data holds key k+1; move on while it does not pass the query.
                if (more_keys && i_status.tq_ge_rd) begin
                    o_cmd.ld_a  = 1'b1;
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = AW'(EW'(r_k) + EW'(2));
                    n_k         = r_k + AW'(1);
                end else begin
                    o_cmd.ld_b = 1'b1;
                    n_state    = S_DIVI;
                end
            end
            S_DIVI: begin
                if (i_status.t2_le_t1) begin
                    o_cmd.res_sel = kviu_pkg::RES_KEYA;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIVS;
                end
            end
            S_DIVS: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_comp  = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.res_sel = kviu_pkg::RES_LERP;
                if (r_comp == 2'd2) begin
                    n_state = S_OUT;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_cnt   <= '0;
            r_comp  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
            r_comp  <= n_comp;
        end
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_state == S_OUT;
endmodule

// ----- design/kviu_checker.sv -----
// Port-level checker of the keyframe interpolator and its bind statement.
`include "keyframe_vector_interpolator_unit_macros.svh"

module kviu_port_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         i_command,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [kviu_pkg::DATA_W-1:0]  o_out_x,
    input logic [kviu_pkg::DATA_W-1:0]  o_out_y,
    input logic [kviu_pkg::DATA_W-1:0]  o_out_z
);
    logic [3*kviu_pkg::DATA_W-1:0] out_vec;
    logic                          in_xfer;

    assign out_vec = {o_out_z, o_out_y, o_out_x};
    assign in_xfer = i_valid && !o_stall;

    // A held result keeps its valid and its value.
    `KVIU_ASSERT(a_hold, o_valid && i_stall |=> o_valid && $stable(out_vec))
    // A keyframe write never produces a result.
    `KVIU_ASSERT(a_write_silent, in_xfer && i_command == kviu_pkg::CMD_WRITE |=> !o_valid)
    // An accepted evaluate makes the input side busy.
    `KVIU_ASSERT(a_eval_busy, in_xfer && i_command == kviu_pkg::CMD_EVAL |=> o_stall)
    // Reset leaves no result pending.
    `KVIU_ASSERT_ANY(a_reset_clear, !i_rst_n |=> !o_valid)
endmodule

bind keyframe_vector_interpolator_unit kviu_port_checker u_kviu_checker (.*);

// ----- sim/kviu_checker.sv -----
// Checker of the keyframe interpolator: tracks transfers, predicts results and compares.
module kviu_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic               i_command,
    input  logic [3:0]         i_key_index,
    input  logic [31:0]        i_time_value,
    input  logic signed [31:0] i_value_x,
    input  logic signed [31:0] i_value_y,
    input  logic signed [31:0] i_value_z,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_out_x,
    input  logic signed [31:0] o_out_y,
    input  logic signed [31:0] o_out_z,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vec;

    logic [31:0] key_times [kviu_pkg::MAX_KEYS_DEF];
    t_vec        key_vecs  [kviu_pkg::MAX_KEYS_DEF];
    logic [4:0]  track_len;
    t_vec        expected_vecs [$];

    function automatic logic signed [31:0] blend(logic signed [31:0] a,
                                                  logic signed [31:0] b,
                                                  logic [16:0] f);
        logic signed [63:0] sum;
        sum = 64'(a) * $signed({47'd0, 17'h10000 - f}) + 64'(b) * $signed({47'd0, f});
        return 32'(sum >>> 16);
    endfunction

    function automatic t_vec track_value(logic [31:0] tq);
        int n;
        int k;
        logic [31:0] t1;
        logic [31:0] t2;
        logic [63:0] frac;
        t_vec r;
        n = int'(track_len);
        if (n < 1) n = 1;
        if (n > kviu_pkg::MAX_KEYS_DEF) n = kviu_pkg::MAX_KEYS_DEF;
        if (tq <= key_times[0]) begin
            r = key_vecs[0];
        end else if (tq >= key_times[n-1]) begin
            r = key_vecs[n-1];
        end else begin
            k = 0;
            while (k + 2 < n && !(key_times[k+1] > tq)) k++;
            t1 = key_times[k];
            t2 = key_times[k+1];
            if (t2 <= t1) begin
                r = key_vecs[k];
            end else begin
                frac = ({32'd0, tq - t1} << 16) / {32'd0, t2 - t1};
                if (frac > 65535) frac = 65535;
                r.x = blend(key_vecs[k].x, key_vecs[k+1].x, frac[16:0]);
                r.y = blend(key_vecs[k].y, key_vecs[k+1].y, frac[16:0]);
                r.z = blend(key_vecs[k].z, key_vecs[k+1].z, frac[16:0]);
            end
        end
        return r;
    endfunction

    assign o_pending = expected_vecs.size();

    always @(posedge i_clk) begin
        t_vec got;
        t_vec want;
        if (!i_rst_n) begin
            foreach (key_times[i]) begin
                key_times[i] <= '0;
                key_vecs[i] <= '0;
            end
            track_len <= 5'd1;
            o_fail_count <= 0;
            expected_vecs.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == 3'd0)
                track_len <= pwdata[4:0];
            if (i_valid && !o_stall) begin
                if (i_command == kviu_pkg::CMD_WRITE) begin
                    key_times[i_key_index] <= i_time_value;
                    key_vecs[i_key_index] <= '{i_value_x, i_value_y, i_value_z};
                end else begin
                    expected_vecs.insert(expected_vecs.size(), track_value(i_time_value));
                end
            end
            if (o_valid && !i_stall) begin
                got = '{o_out_x, o_out_y, o_out_z};
                if (expected_vecs.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_vecs.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- sim/tb_keyframe_vector_interpolator_unit.sv -----
// Testbench top of the keyframe interpolator: stimulus, configuration and verdict.
module tb_keyframe_vector_interpolator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_command = kviu_pkg::CMD_WRITE;
    logic [3:0]         i_key_index = '0;
    logic [31:0]        i_time_value = '0;
    logic signed [31:0] i_value_x = '0;
    logic signed [31:0] i_value_y = '0;
    logic signed [31:0] i_value_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    int                 fail_count;
    int                 pending;
    int                 burst_left = 0;
    int                 stall_mode = 0;

    keyframe_vector_interpolator_unit dut (.*);

    kviu_checker checker_inst (.*, .o_fail_count(fail_count), .o_pending(pending));

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver stall pattern changes mode every so often.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    task automatic reg_write(input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Sends one transfer; the sender idles between bursts of random length.
    task automatic send(input logic cmd, input logic [3:0] idx, input logic [31:0] tv,
                        input logic [31:0] vx, input logic [31:0] vy,
                        input logic [31:0] vz);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_command <= cmd;
        i_key_index <= idx;
        i_time_value <= tv;
        i_value_x <= vx;
        i_value_y <= vy;
        i_value_z <= vz;
        do @(posedge i_clk); while (o_stall);
    endtask

    // The checker records an accepted evaluate at the edge it is taken, so let an edge pass first.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Writes a track of n keys with ascending times and random vectors.
    task automatic load_track(input int n, input logic [31:0] span);
        logic [31:0] t;
        t = $urandom_range(0, 1000);
        for (int i = 0; i < n; i++) begin
            send(kviu_pkg::CMD_WRITE, i[3:0], t, $urandom, $urandom, $urandom);
            t = t + $urandom_range(1, span);
        end
    endtask

    initial begin
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: single key, extremes of the vector fields and of the time.
        send(kviu_pkg::CMD_WRITE, 4'd0, 32'd100, 32'h7fffffff, 32'h80000000, 32'hffffffff);
        send(kviu_pkg::CMD_EVAL, 4'd0, 32'd0, 0, 0, 0);
        send(kviu_pkg::CMD_EVAL, 4'd0, 32'hffffffff, 0, 0, 0);
        drain();
        reg_write(32'd2);
        send(kviu_pkg::CMD_WRITE, 4'd1, 32'hffffffff, 32'h80000000, 32'h7fffffff, 32'h0);
        send(kviu_pkg::CMD_EVAL, 4'd0, 32'd100, 0, 0, 0);
        send(kviu_pkg::CMD_EVAL, 4'd0, 32'd101, 0, 0, 0);
        send(kviu_pkg::CMD_EVAL, 4'd0, 32'h80000000, 0, 0, 0);
        send(kviu_pkg::CMD_EVAL, 4'd0, 32'hfffffffe, 0, 0, 0);
        send(kviu_pkg::CMD_EVAL, 4'd0, 32'hffffffff, 0, 0, 0);
        drain();
        // Full track, including times that are not ascending.
        reg_write(32'd16);
        load_track(16, 32'h00100000);
        send(kviu_pkg::CMD_WRITE, 4'd7, 32'd5, 32'h12345678, 32'h0, 32'hffff0000);
        send(kviu_pkg::CMD_EVAL, 4'd0, 32'h00400000, 0, 0, 0);
        send(kviu_pkg::CMD_EVAL, 4'd0, 32'h00900000, 0, 0, 0);
        send(kviu_pkg::CMD_EVAL, 4'd0, 32'hffffffff, 0, 0, 0);
        drain();
        // Count beyond the store saturates, zero counts as one.
        reg_write(32'd31);
        send(kviu_pkg::CMD_EVAL, 4'd0, 32'h00800000, 0, 0, 0);
        drain();
        reg_write(32'd0);
        send(kviu_pkg::CMD_EVAL, 4'd0, 32'h00800000, 0, 0, 0);
        drain();
        // Random phases: every slot was written above, so any count is safe.
        for (int ph = 0; ph < 24; ph++) begin
            n = (ph % 6 == 0) ? 16 : (ph % 6 == 1) ? 1 : $urandom_range(1, 16);
            reg_write(n);
            if ($urandom_range(0, 2) != 0) load_track(16, $urandom_range(1, 32'h01000000));
            for (int j = 0; j < 60; j++) begin
                if ($urandom_range(0, 9) == 0)
                    send(kviu_pkg::CMD_WRITE, 4'($urandom), $urandom, $urandom, $urandom,
                         $urandom);
                else
                    send(kviu_pkg::CMD_EVAL, 4'($urandom), ($urandom_range(0, 3) == 0) ?
                         $urandom : $urandom_range(0, 32'h10000000), $urandom, $urandom,
                         $urandom);
            end
            drain();
        end
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- keyframe_vector_interpolator_unit.f -----
+incdir+design
design/kviu_pkg.sv
design/kviu_datapath.sv
design/kviu_ctrl.sv
design/keyframe_vector_interpolator_unit.sv
design/kviu_checker.sv
sim/kviu_checker.sv
sim/tb_keyframe_vector_interpolator_unit.sv
